// ===== rtl/core/gaussian_pyramid_reduce_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Gaussian pyramid reduce block
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_PYRAMID_REDUCE_TOP_MACROS_SVH
`define GAUSSIAN_PYRAMID_REDUCE_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every rising edge outside reset.
`define GPR_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check that a condition never holds.
`define GPR_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define GPR_ASSERT(name, prop, msg)
`define GPR_NEVER(name, cond, msg)
`endif

`endif

// ===== rtl/core/gpr_pkg.sv =====
// ----------------------------------------------------------------------------
// gpr_pkg
// Word types, register map and filter modes of the pyramid reduce block.
// ----------------------------------------------------------------------------
`default_nettype none

package gpr_pkg;

	typedef struct packed {
		logic [15:0] in_ch0;
		logic [15:0] in_ch1;
		logic [15:0] in_ch2;
	} pix_word_t;

	typedef struct packed {
		logic [15:0] out_ch0;
		logic [15:0] out_ch1;
		logic [15:0] out_ch2;
		logic        run_last;
		logic        frame_done;
	} res_word_t;

	// Register index, taken from paddr[2]
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic [11:0] FRAME_WIDTH_RST  = 12'd640;
	localparam logic [15:0] FRAME_HEIGHT_RST = 16'd480;

	// 5-tap window shapes: full window, far side reflected once, far side twice
	localparam logic [1:0] TAP_MID = 2'd0;
	localparam logic [1:0] TAP_LOW = 2'd1;
	localparam logic [1:0] TAP_END = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/gaussian_pyramid_reduce_top.sv =====
// ----------------------------------------------------------------------------
// gaussian_pyramid_reduce_top
// 5x5 binomial blur with reflect-101 borders and 2:1 decimation in both axes.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter in raster order on pix_word (pix_valid / pix_stall); reduced
//   pixels leave on res_word (res_valid / res_stall). A word moves on a rising
//   edge where valid is high and stall is low.
//   Frame size is set over the APB port (frame_width at 0x0, frame_height at
//   0x4); any write restarts the frame at row 0, column 0. Write only while
//   the block is idle.
//   Pipeline: input/line-read register (s1, vertical pass), column history
//   (s2, horizontal pass), output register. A result passes through s1, s2
//   and the output register after the pixel causing it is accepted.
//   Throughput: one pixel per cycle while res_stall is low. A pixel that
//   causes k results (k up to 4 at the right edge of the last row) holds
//   the input while s2 emits them; the output register takes one word per cycle.
//   When res_stall is high the output word holds and the pipeline fills; once
//   s1 is blocked pix_stall rises. Reset clears control state and the frame
//   size registers; the four line stores are not cleared, no pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gaussian_pyramid_reduce_top_macros.svh"

module gaussian_pyramid_reduce_top #(
	parameter int MAX_WIDTH   = 2048,
	parameter int SAMPLE_BITS = 16,
	parameter int CHANNELS    = 3
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// pixel input
	input  wire logic               pix_valid,
	output logic                    pix_stall,
	input  wire gpr_pkg::pix_word_t pix_word,
	// reduced output
	output logic                    res_valid,
	input  wire logic               res_stall,
	output gpr_pkg::res_word_t      res_word,
	// configuration
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	localparam int SW  = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
	localparam int VW  = SW + 4;
	localparam int HW  = SW + 8;
	localparam int XW  = $clog2(MAX_WIDTH);
	localparam int WCW = (XW + 1 > 12) ? XW + 1 : 12;

	// Weighted 5-tap sum with reflect-101 folding; t0 is the newest tap.
	function automatic logic [HW-1:0] filt5(
		input logic [HW-1:0] t4,
		input logic [HW-1:0] t3,
		input logic [HW-1:0] t2,
		input logic [HW-1:0] t1,
		input logic [HW-1:0] t0,
		input logic [1:0]    mode,
		input logic          at_edge
	);
		logic [HW-1:0] a4;
		logic [HW-1:0] a3;
		logic [HW-1:0] s;
		a4 = at_edge ? t0 : t4;
		a3 = at_edge ? t1 : t3;
		case (mode)
			gpr_pkg::TAP_MID: s = a4 + (a3 << 2) + (t2 << 2) + (t2 << 1) + (t1 << 2) + t0;
			gpr_pkg::TAP_LOW: s = t3 + (t2 << 2) + (t1 << 2) + (t1 << 1) + t1 + (t0 << 2);
			gpr_pkg::TAP_END: s = (t2 << 1) + (t1 << 3) + (t0 << 2) + (t0 << 1);
			default:          s = '0;
		endcase
		return s;
	endfunction

	// ------------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------------
	logic [11:0] frame_width_q;
	logic [15:0] frame_height_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		case (paddr[2])
			gpr_pkg::REG_FRAME_WIDTH:  prdata = 32'(frame_width_q);
			gpr_pkg::REG_FRAME_HEIGHT: prdata = 32'(frame_height_q);
			default:                   prdata = '0;
		endcase
	end

	// Clamp the frame size into the working range
	logic [WCW-1:0] fw_ext;
	logic [WCW-1:0] w_eff;
	logic [XW-1:0]  w_last;
	logic [15:0]    h_last;

	assign fw_ext = WCW'(frame_width_q);

	always_comb begin
		if (fw_ext < WCW'(3))
			w_eff = WCW'(3);
		else if (fw_ext > WCW'(MAX_WIDTH))
			w_eff = WCW'(MAX_WIDTH);
		else
			w_eff = fw_ext;
	end

	assign w_last = XW'(w_eff - WCW'(1));
	assign h_last = (frame_height_q < 16'd3) ? 16'd2 : frame_height_q - 16'd1;

	// ------------------------------------------------------------------------
	// Handshake and pipeline control
	// ------------------------------------------------------------------------
	logic          pix_acc;
	logic          s1_valid_q;
	logic          s2_valid_q;
	logic [8:0]    pend_s2;
	logic          res_valid_q;
	logic          out_free;
	logic          s2_emit;
	logic          s2_done;
	logic          s2_load;
	logic          s1_adv;
	logic [8:0]    sel_bit;
	logic [1:0]    sel_r;
	logic [1:0]    sel_c;
	logic          sel_last;

	assign out_free  = !res_valid_q || !res_stall;
	assign s2_emit   = s2_valid_q && (pend_s2 != '0) && out_free;
	assign s2_done   = s2_valid_q && ((pend_s2 == '0) || (out_free && sel_last));
	assign s2_load   = !s2_valid_q || s2_done;
	assign s1_adv    = s1_valid_q && s2_load;
	assign pix_stall = s1_valid_q && !s2_load;
	assign pix_acc   = pix_valid && !pix_stall;
	assign res_valid = res_valid_q;

	// ------------------------------------------------------------------------
	// Position counters and result selection for the incoming pixel
	// ------------------------------------------------------------------------
	logic [XW-1:0] col_q;
	logic [15:0]   row_q;
	logic          last_col;
	logic          last_row;
	logic [2:0]    row_mask;
	logic [2:0]    col_mask;

	assign last_col = (col_q == w_last);
	assign last_row = (row_q == h_last);

	// Output rows y-2, y-1, y and output columns x-2, x-1, x
	assign row_mask[0] = (row_q[15:1] != '0) && !row_q[0];
	assign row_mask[1] = last_row && row_q[0];
	assign row_mask[2] = last_row && !row_q[0];
	assign col_mask[0] = (col_q[XW-1:1] != '0) && !col_q[0];
	assign col_mask[1] = last_col && col_q[0];
	assign col_mask[2] = last_col && !col_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= gpr_pkg::FRAME_WIDTH_RST;
			frame_height_q <= gpr_pkg::FRAME_HEIGHT_RST;
			col_q          <= '0;
			row_q          <= '0;
		end else if (cfg_wr) begin
			case (paddr[2])
				gpr_pkg::REG_FRAME_WIDTH:  frame_width_q  <= pwdata[11:0];
				gpr_pkg::REG_FRAME_HEIGHT: frame_height_q <= pwdata[15:0];
				default:                   frame_width_q  <= frame_width_q;
			endcase
			// restart the frame
			col_q <= '0;
			row_q <= '0;
		end else if (pix_acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? 16'd0 : row_q + 16'd1;
			end else begin
				col_q <= col_q + XW'(1);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Line stores: four rows, row r kept in line r mod 4. Read column x of all
	// lines and write the new pixel into its own line on the same edge; the
	// read returns the row four above before it is replaced.
	// ------------------------------------------------------------------------
	logic [CHANNELS-1:0][SW-1:0] pix_in;
	logic [3:0][CHANNELS*SW-1:0] rd_s1;

	always_comb begin
		pix_in[0] = pix_word.in_ch0[SW-1:0];
		if (CHANNELS > 1)
			pix_in[1 % CHANNELS] = pix_word.in_ch1[SW-1:0];
		if (CHANNELS > 2)
			pix_in[2 % CHANNELS] = pix_word.in_ch2[SW-1:0];
	end

	for (genvar ln = 0; ln < 4; ln++) begin : g_line
		logic [CHANNELS*SW-1:0] mem [MAX_WIDTH];

		always_ff @(posedge clk) begin
			if (pix_acc) begin
				rd_s1[ln] <= mem[col_q];
				if (row_q[1:0] == 2'(ln))
					mem[col_q] <= pix_in;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stage 1: pixel plus the four rows above it; vertical pass
	// ------------------------------------------------------------------------
	logic [CHANNELS-1:0][SW-1:0] pix_s1;
	logic [1:0]                  y2_s1;
	logic                        top_s1;
	logic                        xleft_s1;
	logic                        end_s1;
	logic [2:0]                  rm_s1;
	logic [2:0]                  cm_s1;

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			pix_s1   <= pix_in;
			y2_s1    <= row_q[1:0];
			top_s1   <= (row_q == 16'd2);
			xleft_s1 <= (col_q == XW'(2));
			end_s1   <= last_row && last_col;
			rm_s1    <= row_mask;
			cm_s1    <= col_mask;
		end
	end

	// Taps p0 (this row) .. p4 (four rows up), vertical sums for rows y-2, y-1, y
	logic [4:0][CHANNELS-1:0][SW-1:0] ptap;
	logic [2:0][CHANNELS-1:0][VW-1:0] vsum;
	logic [8:0]                       new_pend;

	always_comb begin
		ptap[0] = pix_s1;
		for (int k = 1; k < 5; k++)
			ptap[k] = rd_s1[2'(y2_s1 - 2'(k))];
		for (int ch = 0; ch < CHANNELS; ch++) begin
			vsum[0][ch] = VW'(filt5(HW'(ptap[4][ch]), HW'(ptap[3][ch]), HW'(ptap[2][ch]),
				HW'(ptap[1][ch]), HW'(ptap[0][ch]), gpr_pkg::TAP_MID, top_s1));
			vsum[1][ch] = VW'(filt5(HW'(ptap[4][ch]), HW'(ptap[3][ch]), HW'(ptap[2][ch]),
				HW'(ptap[1][ch]), HW'(ptap[0][ch]), gpr_pkg::TAP_LOW, 1'b0));
			vsum[2][ch] = VW'(filt5(HW'(ptap[4][ch]), HW'(ptap[3][ch]), HW'(ptap[2][ch]),
				HW'(ptap[1][ch]), HW'(ptap[0][ch]), gpr_pkg::TAP_END, 1'b0));
		end
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				new_pend[r*3+c] = rm_s1[r] && cm_s1[c];
	end

	// ------------------------------------------------------------------------
	// Stage 2: five columns of vertical sums per output row; horizontal pass,
	// one result per cycle while the output register is free, in row-major order
	// ------------------------------------------------------------------------
	logic [2:0][4:0][CHANNELS-1:0][VW-1:0] vh_s2;
	logic                                  xleft_s2;
	logic                                  end_s2;

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			for (int r = 0; r < 3; r++) begin
				vh_s2[r][0] <= vsum[r];
				for (int k = 1; k < 5; k++)
					vh_s2[r][k] <= vh_s2[r][k-1];
			end
			xleft_s2 <= xleft_s1;
			end_s2   <= end_s1;
		end
	end

	// Pick the lowest pending result
	always_comb begin
		sel_bit = '0;
		sel_r   = '0;
		sel_c   = '0;
		for (int r = 2; r >= 0; r--)
			for (int c = 2; c >= 0; c--)
				if (pend_s2[r*3+c]) begin
					sel_bit = 9'(1) << (r*3+c);
					sel_r   = 2'(r);
					sel_c   = 2'(c);
				end
		sel_last = ((pend_s2 & ~sel_bit) == '0);
	end

	logic [1:0]               hmode;
	logic [2:0][15:0]         ovals;
	logic [CHANNELS-1:0][HW-1:0] hsum;
	logic [CHANNELS-1:0][HW-1:0] hrnd;
	gpr_pkg::res_word_t       res_next;
	gpr_pkg::res_word_t       res_q;

	always_comb begin
		case (sel_c)
			2'd0:    hmode = gpr_pkg::TAP_MID;
			2'd1:    hmode = gpr_pkg::TAP_LOW;
			2'd2:    hmode = gpr_pkg::TAP_END;
			default: hmode = gpr_pkg::TAP_MID;
		endcase
		ovals = '0;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			hsum[ch] = filt5(HW'(vh_s2[sel_r][4][ch]), HW'(vh_s2[sel_r][3][ch]),
				HW'(vh_s2[sel_r][2][ch]), HW'(vh_s2[sel_r][1][ch]),
				HW'(vh_s2[sel_r][0][ch]), hmode, xleft_s2 && (sel_c == 2'd0));
			// round to nearest, ties up
			hrnd[ch]  = hsum[ch] + HW'(128);
			ovals[ch] = 16'(hrnd[ch][HW-1:8]);
		end
		res_next.out_ch0    = ovals[0];
		res_next.out_ch1    = ovals[1];
		res_next.out_ch2    = ovals[2];
		res_next.run_last   = sel_last;
		res_next.frame_done = sel_last && end_s2;
	end

	// ------------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			pend_s2     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pix_acc)
				s1_valid_q <= 1'b1;
			else if (s1_adv)
				s1_valid_q <= 1'b0;

			if (s1_adv) begin
				s2_valid_q <= 1'b1;
				pend_s2    <= new_pend;
			end else begin
				if (s2_done)
					s2_valid_q <= 1'b0;
				if (s2_emit)
					pend_s2 <= pend_s2 & ~sel_bit;
			end

			if (out_free)
				res_valid_q <= s2_emit;
		end
	end

	// Output register: load a new word when the slot is free and a result is pending
	always_ff @(posedge clk) begin
		if (s2_emit)
			res_q <= res_next;
	end

	assign res_word = res_q;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	`GPR_ASSERT(a_done_is_last, (res_valid && res_word.frame_done) |-> res_word.run_last, "frame_done without run_last")
	`GPR_NEVER(a_col_range, col_q > w_last, "column position beyond row end")
	`GPR_ASSERT(a_pend_count, $countones(pend_s2) <= 4, "more than four results pending")

endmodule

`default_nettype wire

// ===== sim/gaussian_pyramid_reduce_top_tb.sv =====
// ----------------------------------------------------------------------------
// Gaussian pyramid reduce testbench
// Streams three-channel pixels through the 5x5 binomial reduce block for a
// range of frame sizes. A scoreboard predicts every reduced word, with its
// run_last and frame_done flags, and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module gaussian_pyramid_reduce_top_tb;
	import gpr_pkg::*;

	localparam int LINE_MAX      = 2048;
	localparam int DRAIN_CYCLES  = 8;
	localparam int STUCK_LIMIT   = 5000;
	localparam int HOLD_CYCLES   = 80;
	localparam int HOLD_AFTER    = 40;
	localparam int RANDOM_PIXELS = 180;

	// Register byte addresses, index in bit 2
	localparam logic [2:0] ADDR_FRAME_WIDTH  = {REG_FRAME_WIDTH, 2'b00};
	localparam logic [2:0] ADDR_FRAME_HEIGHT = {REG_FRAME_HEIGHT, 2'b00};

	// Pixel content styles
	localparam int PIX_RANDOM = 0;
	localparam int PIX_CHECKER = 1;

	// ------------------------------------------------------------------------
	// Scoreboard: running model of the line stores and window, plus the
	// queue of reduced words still owed by the block.
	// ------------------------------------------------------------------------
	class pyramid_scoreboard;
		logic [15:0] line_buf [4][LINE_MAX][3];
		logic [15:0] win [4][3];
		logic [15:0] cur [3];
		int col, row, width_reg, height_reg;
		res_word_t owed_q[$];
		int errors, n_pixels, n_results;

		function new();
			for (int i = 0; i < 4; i++)
				for (int ch = 0; ch < 3; ch++)
					win[i][ch] = '0;
			col = 0;
			row = 0;
			width_reg = FRAME_WIDTH_RST;
			height_reg = FRAME_HEIGHT_RST;
			errors = 0;
			n_pixels = 0;
			n_results = 0;
		endfunction

		// Any register write restarts the frame; line stores are kept
		function void write_reg(logic idx, int value);
			if (idx == REG_FRAME_WIDTH)
				width_reg = value & 'hfff;
			else
				height_reg = value & 'hffff;
			col = 0;
			row = 0;
		endfunction

		// Reflect-101 border
		function int mirror(int i, int n);
			if (i < 0) i = -i;
			if (i > n - 1) i = 2 * (n - 1) - i;
			if (i < 0) i = 0;
			if (i > n - 1) i = n - 1;
			return i;
		endfunction

		// Current row comes from the window, older rows from the line stores
		function logic [15:0] tap(int r, int c, int ch, int y, int x);
			int k;
			if (r == y) begin
				if (c >= x) return cur[ch];
				k = c - (x - 4);
				if (k < 0) k = 0;
				return win[k & 3][ch];
			end
			if (r < 0 || c < 0 || c >= LINE_MAX) return '0;
			return line_buf[r & 3][c][ch];
		endfunction

		function res_word_t blur_at(int orow, int ocol, int y, int x, int w, int h);
			int wt[5];
			longint acc;
			int r, c;
			logic [15:0] v[3];
			res_word_t o;
			wt = '{1, 4, 6, 4, 1};
			for (int ch = 0; ch < 3; ch++) begin
				acc = 0;
				for (int i = 0; i < 5; i++) begin
					r = mirror(orow + i - 2, h);
					for (int j = 0; j < 5; j++) begin
						c = mirror(ocol + j - 2, w);
						acc += longint'(wt[i] * wt[j]) * longint'(tap(r, c, ch, y, x));
					end
				end
				acc = (acc + 128) >>> 8;
				v[ch] = acc[15:0];
			end
			o.out_ch0 = v[0];
			o.out_ch1 = v[1];
			o.out_ch2 = v[2];
			o.run_last = 1'b0;
			o.frame_done = 1'b0;
			return o;
		endfunction

		// Predict the words caused by one accepted pixel, then advance state
		function void note_pixel(pix_word_t p);
			int w, h, x, y, c;
			int rows[$], cols[$];
			res_word_t batch[$];
			w = width_reg;
			h = height_reg;
			if (w < 3) w = 3;
			if (w > LINE_MAX) w = LINE_MAX;
			if (h < 3) h = 3;
			if (col >= w) col = 0;
			if (row >= h) row = 0;
			x = col;
			y = row;
			cur[0] = p.in_ch0;
			cur[1] = p.in_ch1;
			cur[2] = p.in_ch2;

			if (y >= 2 && ((y - 2) & 1) == 0) rows.push_back(y - 2);
			if (y == h - 1) begin
				if (((y - 1) & 1) == 0) rows.push_back(y - 1);
				if ((y & 1) == 0) rows.push_back(y);
			end
			if (x >= 2 && ((x - 2) & 1) == 0) cols.push_back(x - 2);
			if (x == w - 1) begin
				if (((x - 1) & 1) == 0) cols.push_back(x - 1);
				if ((x & 1) == 0) cols.push_back(x);
			end
			foreach (rows[a])
				foreach (cols[b])
					batch.push_back(blur_at(rows[a], cols[b], y, x, w, h));
			if (batch.size() > 0) begin
				batch[batch.size() - 1].run_last = 1'b1;
				if (y == h - 1 && x == w - 1)
					batch[batch.size() - 1].frame_done = 1'b1;
			end
			foreach (batch[i]) owed_q.push_back(batch[i]);

			// Retire the oldest window column into the line store
			if (x >= 4)
				for (int ch = 0; ch < 3; ch++)
					line_buf[y & 3][x - 4][ch] = win[0][ch];
			for (int i = 0; i < 3; i++)
				for (int ch = 0; ch < 3; ch++)
					win[i][ch] = win[i + 1][ch];
			for (int ch = 0; ch < 3; ch++)
				win[3][ch] = cur[ch];

			if (x == w - 1) begin
				for (int i = 0; i < 4; i++) begin
					c = x - 3 + i;
					if (c >= 0 && c < LINE_MAX)
						for (int ch = 0; ch < 3; ch++)
							line_buf[y & 3][c][ch] = win[i][ch];
				end
				col = 0;
				row = (y == h - 1) ? 0 : y + 1;
			end else begin
				col = x + 1;
			end
			n_pixels++;
		endfunction

		task report(string msg);
			$display("ERROR: %s", msg);
			errors++;
		endtask

		task check_result(res_word_t got);
			res_word_t want;
			if (owed_q.size() == 0) begin
				report($sformatf("unexpected reduced word %h", got));
				return;
			end
			want = owed_q.pop_front();
			n_results++;
			if (got.out_ch0 !== want.out_ch0)
				report($sformatf("word %0d out_ch0 %h, want %h", n_results,
					got.out_ch0, want.out_ch0));
			if (got.out_ch1 !== want.out_ch1)
				report($sformatf("word %0d out_ch1 %h, want %h", n_results,
					got.out_ch1, want.out_ch1));
			if (got.out_ch2 !== want.out_ch2)
				report($sformatf("word %0d out_ch2 %h, want %h", n_results,
					got.out_ch2, want.out_ch2));
			if (got.run_last !== want.run_last)
				report($sformatf("word %0d run_last %b, want %b", n_results,
					got.run_last, want.run_last));
			if (got.frame_done !== want.frame_done)
				report($sformatf("word %0d frame_done %b, want %b", n_results,
					got.frame_done, want.frame_done));
		endtask
	endclass

	// ------------------------------------------------------------------------
	// Block and its drivers
	// ------------------------------------------------------------------------
	logic        clk;
	logic        arst_n;
	logic        pix_valid;
	logic        pix_stall;
	pix_word_t   pix_word;
	logic        res_valid;
	logic        res_stall;
	res_word_t   res_word;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	pyramid_scoreboard sb;
	int burst_left;
	int n_settings;

	gaussian_pyramid_reduce_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix_word (pix_word),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_word (res_word),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Receiver: check every accepted word, stall on a changing pattern.
	// Once enough pixels are in, hold off for a long stretch so the block
	// fills up and pushes back on the pixel side.
	initial begin
		int hold_left;
		int mode;
		int mode_left;
		bit held;
		hold_left = 0;
		mode = 0;
		mode_left = 0;
		held = 0;
		res_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && !res_stall)
				sb.check_result(res_word);
			if (!held && sb.n_pixels >= HOLD_AFTER) begin
				held = 1;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				// no stall, light stall or heavy stall for a while
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(8, 40);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else begin
				case (mode)
					0: res_stall <= 1'b0;
					1: res_stall <= ($urandom_range(0, 3) == 0);
					default: res_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// Watchdog: end the run if nothing moves for too long
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((pix_valid && !pix_stall) || (res_valid && !res_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STUCK_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// APB write: setup cycle, then access until pready
	task apb_write(logic [2:0] addr, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.write_reg(addr[2], value);
	endtask

	// Wait for every owed word, then let the pipeline settle
	task drain();
		while (sb.owed_q.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function pix_word_t make_pixel(int style, int idx);
		pix_word_t p;
		if (style == PIX_CHECKER) begin
			p = idx[0] ? '1 : '0;
		end else begin
			case ($urandom_range(0, 7))
				0: p = '0;
				1: p = '1;
				default: p = {$urandom, $urandom};
			endcase
		end
		return p;
	endfunction

	// Offer one pixel and hold it until accepted; bursts and gaps follow
	task send_pixels(int count, int style);
		int gap;
		for (int i = 0; i < count; i++) begin
			pix_valid <= 1'b1;
			pix_word <= make_pixel(style, i);
			do @(posedge clk); while (pix_stall);
			sb.note_pixel(pix_word);
			burst_left--;
			gap = 0;
			if (burst_left <= 0) begin
				gap = $urandom_range(1, 6);
				burst_left = $urandom_range(1, 24);
			end
			if (gap > 0 || i == count - 1) begin
				pix_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// New frame size while idle, then stream pixels
	task run_setting(int w, int h, int count, int style);
		drain();
		apb_write(ADDR_FRAME_WIDTH, w);
		apb_write(ADDR_FRAME_HEIGHT, h);
		n_settings++;
		send_pixels(count, style);
	endtask

	initial begin
		int w, h;
		sb = new();
		n_settings = 0;
		burst_left = $urandom_range(1, 24);
		arst_n = 1'b0;
		pix_valid = 1'b0;
		pix_word = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: smallest frame with full-scale checkerboard, then an
		// odd-by-odd frame whose last pixel flushes four words at once
		run_setting(3, 3, 9, PIX_CHECKER);
		run_setting(5, 3, 15, PIX_RANDOM);

		// Random small frames, sometimes two back to back or a partial one
		while (sb.n_pixels < 24 + RANDOM_PIXELS) begin
			w = $urandom_range(3, 10);
			h = $urandom_range(3, 8);
			case ($urandom_range(0, 3))
				0: run_setting(w, h, 2 * w * h, PIX_RANDOM);
				1: run_setting(w, h, $urandom_range(1, w * h - 1), PIX_RANDOM);
				default: run_setting(w, h, w * h, PIX_RANDOM);
			endcase
		end

		// Out-of-range and extreme register values
		run_setting(1, 0, 9, PIX_RANDOM);        // both act as 3
		run_setting(3, 65535, 20, PIX_RANDOM);   // tallest frame, partial
		run_setting(2048, 65535, 12, PIX_RANDOM);
		run_setting(4095, 3, 2048 * 3, PIX_RANDOM); // acts as widest row
		run_setting(7, 5, 35, PIX_RANDOM);

		drain();
		$display("Covered %0d pixels and %0d reduced words over %0d frame settings,",
			sb.n_pixels, sb.n_results, n_settings);
		$display("including clamped sizes, widest rows and a long output hold-off.");
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl/core
rtl/core/gpr_pkg.sv
rtl/core/gaussian_pyramid_reduce_top.sv
sim/gaussian_pyramid_reduce_top_tb.sv
